@@ rtl/eeprom_record_store_assert.svh @@
// Assertion macros used by the record store RTL.
`ifndef EEPROM_RECORD_STORE_ASSERT_SVH
`define EEPROM_RECORD_STORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ERS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ERS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ers_pkg.sv @@
// Constants and types of the record store.
`default_nettype none
package ers_pkg;

    localparam int MEM_BYTES   = 128;
    localparam int MAX_PAYLOAD = 63;
    localparam int HDR_BYTES   = 4;
    localparam int SIZE_CAP    = 63;

    localparam int ADDR_W = $clog2(MEM_BYTES);
    // walk pointer must hold a header address plus header and a full size byte
    localparam int WALK_W = $clog2(MEM_BYTES + HDR_BYTES + 256);

    localparam logic [7:0] MARK_LIVE  = 8'h55;
    localparam logic [7:0] MARK_FREED = 8'hAA;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

endpackage
`default_nettype wire

@@ rtl/ers_store_mem.sv @@
// Byte store: single-port synchronous RAM with per-byte valid bits cleared at reset.
`default_nettype none
module ers_store_mem
    import ers_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t req,
    output logic [7:0]    rdata
);

    logic [7:0]           mem [MEM_BYTES];
    logic [MEM_BYTES-1:0] valid_reg;
    logic [7:0]           mem_q_reg;
    logic                 vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            mem_q_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                vld_q_reg <= valid_reg[req.addr];
            end
        end
    end

    // never-written bytes read as zero
    assign rdata = vld_q_reg ? mem_q_reg : 8'h00;

endmodule
`default_nettype wire

@@ rtl/eeprom_record_store.sv @@
// Log-structured record store: header walk, free, append and payload read-out.
//
//  channel   strobe        ports
//  -------   -----------   -----------------------------------------------------
//  request   start & !busy mode, record_id, record_size, data_byte
//  result    result_valid  status, data_byte_res, byte_valid, stored_size, last
//
// A read or write walks headers from address 0: for each header a bound
// check, 4 single-byte RAM reads and an evaluate, and in a write a free of a match.
// A write then lays down the 4 header bytes and reports; a read streams
// one payload byte per cycle. Payload requests of a write give no result.
// All store accesses share the single byte-wide store port. Reset clears the
// store at once through per-byte valid bits. Results cannot be stalled.
`default_nettype none
module eeprom_record_store
    import ers_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [15:0] record_id,
    input  wire logic [5:0]  record_size,
    input  wire logic [7:0]  data_byte,
    output logic             result_valid,
    output logic [1:0]       status,
    output logic [7:0]       data_byte_res,
    output logic             byte_valid,
    output logic [5:0]       stored_size,
    output logic             last
);

`include "eeprom_record_store_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_HDR,
        S_EVAL,
        S_FREE,
        S_APPEND,
        S_RESP,
        S_RDATA
    } state_t;

    state_t            state_reg;
    logic [WALK_W-1:0] a_reg;
    logic [2:0]        cnt_reg;
    logic [3:0][7:0]   hdr_reg;
    logic              mode_reg;
    logic [15:0]       id_reg;
    logic [5:0]        size_reg;
    logic [1:0]        st_reg;
    logic [WALK_W-1:0] append_reg;
    logic [5:0]        bytes_left_reg;
    logic              pending_reg;
    logic              rejected_reg;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [5:0]        rd_cnt_reg;
    logic [5:0]        rd_n_reg;
    logic              rd_pend_reg;
    logic              rd_last_pend_reg;

    logic              result_valid_reg;
    logic [1:0]        status_reg;
    logic [7:0]        data_reg;
    logic              byte_valid_reg;
    logic [5:0]        stored_size_reg;
    logic              last_reg;

    mem_req_t          mem_req;
    logic [7:0]        rdata;

    logic              accept;
    logic              hdr_live;
    logic              hdr_freed;
    logic              hdr_match;
    logic [WALK_W-1:0] next_a;
    logic [WALK_W-1:0] fit_end;
    logic [WALK_W-1:0] avail;
    logic [5:0]        cap_n;
    logic [5:0]        rd_n;
    logic [WALK_W-1:0] a_plus_cnt;

    ers_store_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign hdr_live  = (hdr_reg[0] == MARK_LIVE);
    assign hdr_freed = (hdr_reg[0] == MARK_FREED);
    assign hdr_match = hdr_live && ({hdr_reg[3], hdr_reg[2]} == id_reg);
    assign next_a    = a_reg + WALK_W'(HDR_BYTES) + WALK_W'(hdr_reg[1]);
    assign fit_end   = a_reg + WALK_W'(HDR_BYTES) + WALK_W'(size_reg);
    assign avail     = WALK_W'(MEM_BYTES) - WALK_W'(HDR_BYTES) - a_reg;
    assign cap_n     = (hdr_reg[1] > 8'(SIZE_CAP)) ? 6'(SIZE_CAP) : hdr_reg[1][5:0];
    assign rd_n      = (WALK_W'(cap_n) > avail) ? avail[5:0] : cap_n;
    assign a_plus_cnt = a_reg + WALK_W'(cnt_reg);

    always_comb
    begin
        mem_req = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && pending_reg)
                begin
                    mem_req.wr_en = !rejected_reg && (append_reg < WALK_W'(MEM_BYTES));
                    mem_req.addr  = append_reg[ADDR_W-1:0];
                    mem_req.wdata = data_byte;
                end
            end
            S_HDR:
            begin
                mem_req.rd_en = (cnt_reg != 3'd4);
                mem_req.addr  = a_plus_cnt[ADDR_W-1:0];
            end
            S_FREE:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = a_reg[ADDR_W-1:0];
                mem_req.wdata = MARK_FREED;
            end
            S_APPEND:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = a_plus_cnt[ADDR_W-1:0];
                case (cnt_reg[1:0])
                    2'd0:    mem_req.wdata = MARK_LIVE;
                    2'd1:    mem_req.wdata = {2'b00, size_reg};
                    2'd2:    mem_req.wdata = id_reg[7:0];
                    default: mem_req.wdata = id_reg[15:8];
                endcase
            end
            S_RDATA:
            begin
                mem_req.rd_en = 1'b1;
                mem_req.addr  = rd_ptr_reg;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            a_reg            <= '0;
            cnt_reg          <= '0;
            hdr_reg          <= '0;
            mode_reg         <= 1'b0;
            id_reg           <= '0;
            size_reg         <= '0;
            st_reg           <= ST_OK;
            append_reg       <= '0;
            bytes_left_reg   <= '0;
            pending_reg      <= 1'b0;
            rejected_reg     <= 1'b0;
            rd_ptr_reg       <= '0;
            rd_cnt_reg       <= '0;
            rd_n_reg         <= '0;
            rd_pend_reg      <= 1'b0;
            rd_last_pend_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            status_reg       <= ST_OK;
            data_reg         <= '0;
            byte_valid_reg   <= 1'b0;
            stored_size_reg  <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            rd_pend_reg      <= (state_reg == S_RDATA);
            rd_last_pend_reg <= (state_reg == S_RDATA) && (rd_cnt_reg == rd_n_reg - 6'd1);

            // payload byte of a read, once its RAM read data is back
            if (rd_pend_reg)
            begin
                result_valid_reg <= 1'b1;
                status_reg       <= ST_OK;
                data_reg         <= rdata;
                byte_valid_reg   <= 1'b1;
                stored_size_reg  <= rd_n_reg;
                last_reg         <= rd_last_pend_reg;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (pending_reg)
                        begin
                            append_reg     <= append_reg + WALK_W'(1);
                            bytes_left_reg <= bytes_left_reg - 6'd1;
                            if (bytes_left_reg == 6'd1)
                            begin
                                pending_reg  <= 1'b0;
                                rejected_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            mode_reg  <= mode;
                            id_reg    <= record_id;
                            size_reg  <= record_size;
                            a_reg     <= '0;
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    cnt_reg <= '0;
                    if (a_reg + WALK_W'(HDR_BYTES) > WALK_W'(MEM_BYTES))
                    begin
                        if (mode_reg)
                        begin
                            result_valid_reg <= 1'b1;
                            status_reg       <= ST_NOT_FOUND;
                            data_reg         <= '0;
                            byte_valid_reg   <= 1'b0;
                            stored_size_reg  <= '0;
                            last_reg         <= 1'b1;
                            state_reg        <= S_IDLE;
                        end
                        else
                        begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_RESP;
                        end
                    end
                    else
                    begin
                        state_reg <= S_HDR;
                    end
                end
                S_HDR:
                begin
                    if (cnt_reg != 3'd0)
                    begin
                        hdr_reg[2'(cnt_reg - 3'd1)] <= rdata;
                    end
                    if (cnt_reg == 3'd4)
                    begin
                        state_reg <= S_EVAL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_EVAL:
                begin
                    cnt_reg <= '0;
                    if (mode_reg)
                    begin
                        if (hdr_match)
                        begin
                            if (rd_n == 6'd0)
                            begin
                                result_valid_reg <= 1'b1;
                                status_reg       <= ST_OK;
                                data_reg         <= '0;
                                byte_valid_reg   <= 1'b0;
                                stored_size_reg  <= '0;
                                last_reg         <= 1'b1;
                                state_reg        <= S_IDLE;
                            end
                            else
                            begin
                                rd_ptr_reg <= ADDR_W'(a_reg + WALK_W'(HDR_BYTES));
                                rd_cnt_reg <= '0;
                                rd_n_reg   <= rd_n;
                                state_reg  <= S_RDATA;
                            end
                        end
                        else if (hdr_live || hdr_freed)
                        begin
                            a_reg     <= next_a;
                            state_reg <= S_WALK;
                        end
                        else
                        begin
                            result_valid_reg <= 1'b1;
                            status_reg       <= ST_NOT_FOUND;
                            data_reg         <= '0;
                            byte_valid_reg   <= 1'b0;
                            stored_size_reg  <= '0;
                            last_reg         <= 1'b1;
                            state_reg        <= S_IDLE;
                        end
                    end
                    else
                    begin
                        if (hdr_match)
                        begin
                            state_reg <= S_FREE;
                        end
                        else if (hdr_live || hdr_freed)
                        begin
                            a_reg     <= next_a;
                            state_reg <= S_WALK;
                        end
                        else if ((6'(MAX_PAYLOAD) < size_reg) ||
                                 (fit_end > WALK_W'(MEM_BYTES)))
                        begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_APPEND;
                        end
                    end
                end
                S_FREE:
                begin
                    a_reg     <= next_a;
                    state_reg <= S_WALK;
                end
                S_APPEND:
                begin
                    if (cnt_reg == 3'd3)
                    begin
                        append_reg <= a_reg + WALK_W'(HDR_BYTES);
                        st_reg     <= ST_OK;
                        state_reg  <= S_RESP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_RESP:
                begin
                    result_valid_reg <= 1'b1;
                    status_reg       <= st_reg;
                    data_reg         <= '0;
                    byte_valid_reg   <= 1'b0;
                    stored_size_reg  <= '0;
                    last_reg         <= 1'b1;
                    if (size_reg != 6'd0)
                    begin
                        pending_reg    <= 1'b1;
                        rejected_reg   <= (st_reg != ST_OK);
                        bytes_left_reg <= size_reg;
                    end
                    state_reg <= S_IDLE;
                end
                S_RDATA:
                begin
                    rd_ptr_reg <= rd_ptr_reg + ADDR_W'(1);
                    rd_cnt_reg <= rd_cnt_reg + 6'd1;
                    if (rd_cnt_reg == rd_n_reg - 6'd1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign data_byte_res = data_reg;
    assign byte_valid    = byte_valid_reg;
    assign stored_size   = stored_size_reg;
    assign last          = last_reg;

    `ERS_ASSERT_IMP(a_pending_idle, pending_reg, state_reg == S_IDLE, "payload pending outside idle")
    `ERS_ASSERT_IMP(a_pending_count, pending_reg, bytes_left_reg != 6'd0, "payload pending with zero count")
    `ERS_ASSERT_NXT(a_last_gap, result_valid && last, !result_valid, "result right after last")
    `ERS_ASSERT_IMP(a_byte_ok, result_valid && byte_valid, status == ST_OK, "payload byte with bad status")
    `ERS_ASSERT_IMP(a_port_excl, mem_req.wr_en, !mem_req.rd_en, "store read and write together")

endmodule
`default_nettype wire

@@ bench/ers_bench_pkg.sv @@
// Request kinds shared by the record store bench files.
`timescale 1ns / 1ps
package ers_bench_pkg;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_READ  = 1'b1
    } req_kind_e;

endpackage

@@ bench/record_store_checker.sv @@
// Record store checker: predicts results from accepted requests and compares them.
`timescale 1ns / 1ps
module record_store_checker
    import ers_pkg::*;
    import ers_bench_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        mode,
    input  logic [15:0] record_id,
    input  logic [5:0]  record_size,
    input  logic [7:0]  data_byte,
    input  logic        result_valid,
    input  logic [1:0]  status,
    input  logic [7:0]  data_byte_res,
    input  logic        byte_valid,
    input  logic [5:0]  stored_size,
    input  logic        last,
    output int          fail_count,
    output int          awaited_count,
    output int          checked_count,
    output int          full_count,
    output int          miss_count
);

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data;
        logic       valid;
        logic [5:0] size;
        logic       last;
    } record_result_t;

    logic [7:0]     mem_image [MEM_BYTES];
    logic [15:0]    tail_addr;
    logic [5:0]     payload_left;
    bit             in_payload;
    bit             payload_dropped;
    record_result_t awaited_results [$];

    function automatic logic [15:0] header_key(int a);
        return {mem_image[a+3], mem_image[a+2]};
    endfunction

    function automatic record_result_t make_result(logic [1:0] st, logic [7:0] d, logic v,
                                                   logic [5:0] sz, logic l);
        record_result_t r;
        r.status = st;
        r.data   = d;
        r.valid  = v;
        r.size   = sz;
        r.last   = l;
        return r;
    endfunction

    // Walk headers, free live matches, then append at the end mark.
    function automatic logic [1:0] append_record(logic [15:0] id, logic [5:0] sz);
        int a;
        a = 0;
        while (1) begin
            if (a + HDR_BYTES > MEM_BYTES)
                return ST_FULL;
            if (mem_image[a] == MARK_LIVE || mem_image[a] == MARK_FREED) begin
                if (mem_image[a] == MARK_LIVE && header_key(a) == id)
                    mem_image[a] = MARK_FREED;
                a = a + HDR_BYTES + int'(mem_image[a+1]);
            end
            else begin
                if (int'(sz) > MAX_PAYLOAD || a + HDR_BYTES + int'(sz) > MEM_BYTES)
                    return ST_FULL;
                mem_image[a]   = MARK_LIVE;
                mem_image[a+1] = {2'b00, sz};
                mem_image[a+2] = id[7:0];
                mem_image[a+3] = id[15:8];
                tail_addr      = 16'(a + HDR_BYTES);
                return ST_OK;
            end
        end
    endfunction

    task automatic queue_read_payload(logic [15:0] id);
        int a;
        int n;
        bit hit;
        a   = 0;
        hit = 0;
        while (!hit && a + HDR_BYTES <= MEM_BYTES &&
               (mem_image[a] == MARK_LIVE || mem_image[a] == MARK_FREED)) begin
            if (mem_image[a] == MARK_LIVE && header_key(a) == id)
                hit = 1;
            else
                a = a + HDR_BYTES + int'(mem_image[a+1]);
        end
        if (!hit) begin
            awaited_results.push_back(make_result(ST_NOT_FOUND, 8'h00, 1'b0, 6'd0, 1'b1));
        end
        else begin
            n = int'(mem_image[a+1]);
            if (n > SIZE_CAP)
                n = SIZE_CAP;
            if (a + HDR_BYTES + n > MEM_BYTES)
                n = MEM_BYTES - a - HDR_BYTES;
            if (n == 0)
                awaited_results.push_back(make_result(ST_OK, 8'h00, 1'b0, 6'd0, 1'b1));
            for (int k = 0; k < n; k++)
                awaited_results.push_back(make_result(ST_OK, mem_image[a+HDR_BYTES+k], 1'b1,
                                                      6'(n), k == n - 1));
        end
    endtask

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        record_result_t want;
        logic [1:0]     st;
        if (!rst_n) begin
            for (int i = 0; i < MEM_BYTES; i++)
                mem_image[i] = 8'h00;
            tail_addr       = 16'd0;
            payload_left    = 6'd0;
            in_payload      = 0;
            payload_dropped = 0;
            awaited_results.delete();
            fail_count      = 0;
            checked_count   = 0;
            full_count      = 0;
            miss_count      = 0;
        end
        else begin
            if (result_valid === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual status %0d data %0d",
                             $time, status, data_byte_res);
                end
                else begin
                    want = awaited_results.pop_front();
                    checked_count++;
                    if (want.status == ST_FULL)
                        full_count++;
                    if (want.status == ST_NOT_FOUND)
                        miss_count++;
                    compare_field("status", {6'd0, want.status}, {6'd0, status});
                    compare_field("data_byte_res", want.data, data_byte_res);
                    compare_field("byte_valid", {7'd0, want.valid}, {7'd0, byte_valid});
                    compare_field("stored_size", {2'd0, want.size}, {2'd0, stored_size});
                    compare_field("last", {7'd0, want.last}, {7'd0, last});
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                if (in_payload) begin
                    // payload byte of a pending write, no result
                    if (!payload_dropped && tail_addr < MEM_BYTES)
                        mem_image[tail_addr] = data_byte;
                    tail_addr    = tail_addr + 16'd1;
                    payload_left = payload_left - 6'd1;
                    if (payload_left == 6'd0) begin
                        in_payload      = 0;
                        payload_dropped = 0;
                    end
                end
                else if (mode == REQ_READ) begin
                    queue_read_payload(record_id);
                end
                else begin
                    st = append_record(record_id, record_size);
                    if (record_size != 6'd0) begin
                        in_payload      = 1;
                        payload_dropped = (st != ST_OK);
                        payload_left    = record_size;
                    end
                    awaited_results.push_back(make_result(st, 8'h00, 1'b0, 6'd0, 1'b1));
                end
            end
        end
        awaited_count = awaited_results.size();
    end

endmodule

@@ bench/eeprom_record_store_tb.sv @@
// Top of the record store bench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module eeprom_record_store_tb;
    import ers_bench_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 150;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic        mode        = 1'b0;
    logic [15:0] record_id   = 16'd0;
    logic [5:0]  record_size = 6'd0;
    logic [7:0]  data_byte   = 8'd0;

    logic        busy;
    logic        result_valid;
    logic [1:0]  status;
    logic [7:0]  data_byte_res;
    logic        byte_valid;
    logic [5:0]  stored_size;
    logic        last;

    int fail_count;
    int awaited_count;
    int checked_count;
    int full_count;
    int miss_count;
    int sent_count  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    always #5 clk = ~clk;

    eeprom_record_store DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .record_id     (record_id),
        .record_size   (record_size),
        .data_byte     (data_byte),
        .result_valid  (result_valid),
        .status        (status),
        .data_byte_res (data_byte_res),
        .byte_valid    (byte_valid),
        .stored_size   (stored_size),
        .last          (last)
    );

    record_store_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .record_id     (record_id),
        .record_size   (record_size),
        .data_byte     (data_byte),
        .result_valid  (result_valid),
        .status        (status),
        .data_byte_res (data_byte_res),
        .byte_valid    (byte_valid),
        .stored_size   (stored_size),
        .last          (last),
        .fail_count    (fail_count),
        .awaited_count (awaited_count),
        .checked_count (checked_count),
        .full_count    (full_count),
        .miss_count    (miss_count)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Hold a request until accepted; returns at the accepting edge.
    task automatic drive_request(req_kind_e kind, logic [15:0] id, logic [5:0] sz,
                                 logic [7:0] d);
        @(negedge clk);
        start       <= 1'b1;
        mode        <= kind;
        record_id   <= id;
        record_size <= sz;
        data_byte   <= d;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sent_count++;
    endtask

    // idle with start low; fields wander meanwhile
    task automatic idle_cycles(int n);
        if (n > 0) begin
            @(negedge clk);
            start       <= 1'b0;
            mode        <= 1'($urandom);
            record_id   <= 16'($urandom);
            record_size <= 6'($urandom);
            data_byte   <= 8'($urandom);
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    task automatic paced_request(req_kind_e kind, logic [15:0] id, logic [5:0] sz,
                                 logic [7:0] d);
        if (burst_left == 0) begin
            idle_cycles($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        drive_request(kind, id, sz, d);
    endtask

    task automatic store_record(logic [15:0] id, logic [5:0] sz);
        paced_request(REQ_WRITE, id, sz, 8'($urandom));
        // payload requests: mode, id and size must be ignored
        for (int k = 0; k < int'(sz); k++)
            paced_request($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, 16'($urandom),
                          6'($urandom), 8'($urandom));
    endtask

    task automatic fetch_record(logic [15:0] id);
        paced_request(REQ_READ, id, 6'($urandom), 8'($urandom));
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_count != 0)
            @(posedge clk);
    endtask

    // small id pool so writes free and reads hit
    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'h0002;
            3: return 16'h0003;
            4: return 16'hFFFF;
            5: return 16'h8000;
            6: return 16'h1234;
            7: return 16'h00FF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 6'd63;
        if (r < 12)
            return 6'($urandom_range(7, 62));
        return 6'($urandom_range(0, 6));
    endfunction

    initial
    begin
        int target;
        int r;
        bit paused;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty store, empty record, overwrite, small records
        fetch_record(16'h0000);
        store_record(16'hFFFF, 6'd0);
        fetch_record(16'hFFFF);
        store_record(16'h0000, 6'd3);
        fetch_record(16'h0000);
        store_record(16'h0000, 6'd2);
        fetch_record(16'h0000);
        fetch_record(16'h1234);
        store_record(16'h00FF, 6'd1);
        fetch_record(16'h00FF);
        pause_until_drained();

        // largest payload once while it still fits, then a rewrite that cannot fit
        store_record(16'h8000, 6'd63);
        fetch_record(16'h8000);
        store_record(16'h8000, 6'd63);
        fetch_record(16'h8000);

        target = sent_count + RANDOM_ITEMS;
        paused = 0;
        while (sent_count < target) begin
            if (!paused && sent_count > target - RANDOM_ITEMS / 2) begin
                pause_until_drained();
                paused = 1;
            end
            r = $urandom_range(0, 99);
            if (r < 45)
                store_record(pick_id(), pick_size());
            else if (r < 90)
                fetch_record(pick_id());
            else
                fetch_record(16'($urandom));
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Issued %0d requests; checked %0d results in %0d cycles", sent_count,
                 checked_count, cycle_count);
        $display("Results included %0d store-full and %0d id-miss reports", full_count,
                 miss_count);
        if (fail_count == 0 && awaited_count == 0) begin
            $display("Simulation PASSED");
        end
        else begin
            $display("%0d mismatches, %0d results still awaited", fail_count, awaited_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ eeprom_record_store.f @@
+incdir+rtl
rtl/ers_pkg.sv
rtl/ers_store_mem.sv
rtl/eeprom_record_store.sv
bench/ers_bench_pkg.sv
bench/record_store_checker.sv
bench/eeprom_record_store_tb.sv
